>>> design/arx_pkg.sv
package arx_pkg;

  localparam int ROUND_PAIRS_DEF = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int BLOCK_BYTES     = 64;
  localparam int POS_W           = 7;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] CONST_A = 32'hd2436335;
  localparam logic [31:0] CONST_B = 32'hb2052534;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY01,
    REG_KEY23,
    REG_KEY45,
    REG_KEY67,
    REG_NONCE01,
    REG_NONCE23,
    REG_NONCE4,
    REG_COUNTER
  } cfg_reg_t;

  // One queued item, already split into restart and data work.
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       ends;
  } item_t;

  // Requests from the byte engine to the keystream generator.
  typedef struct packed {
    logic restart;
    logic take;
  } kg_ctrl_t;

  function automatic word_t rotl(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic block_t build_image(input logic [63:0] k01, input logic [63:0] k23,
                                         input logic [63:0] k45, input logic [63:0] k67,
                                         input logic [63:0] n01, input logic [63:0] n23,
                                         input logic [31:0] n4, input logic [31:0] ctr);
    block_t img;
    img[0]  = k01[31:0];
    img[1]  = k01[63:32];
    img[2]  = k23[31:0];
    img[3]  = k23[63:32];
    img[4]  = k45[31:0];
    img[5]  = k45[63:32];
    img[6]  = k67[31:0];
    img[7]  = k67[63:32];
    img[8]  = n01[31:0];
    img[9]  = n01[63:32];
    img[10] = CONST_A;
    img[11] = CONST_B;
    img[12] = n23[31:0];
    img[13] = n23[63:32];
    img[14] = n4;
    img[15] = ctr;
    return img;
  endfunction

  // One mixing round. The four add groups touch disjoint words, so the
  // depth is one four-input XOR and two dependent adds.
  function automatic block_t mix(input block_t s_in);
    block_t s;
    s = s_in;
    s[0] = s[0] ^ s[15] ^ s[14] ^ s[13];
    s[1] = s[1] ^ s[12] ^ s[11] ^ s[10];
    s[2] = s[2] ^ s[9] ^ s[8] ^ s[7];
    s[3] = s[3] ^ s[6] ^ s[5] ^ s[4];

    s[0]  = s[0] + rotl(s[5], 3);
    s[5]  = s[5] + rotl(s[10], 5);
    s[10] = s[10] + rotl(s[15], 7);
    s[15] = s[15] + s[0];

    s[4]  = s[4] + rotl(s[9], 11);
    s[9]  = s[9] + rotl(s[14], 13);
    s[14] = s[14] + rotl(s[3], 17);
    s[3]  = s[3] + s[4];

    s[8]  = s[8] + rotl(s[13], 19);
    s[13] = s[13] + rotl(s[2], 23);
    s[2]  = s[2] + rotl(s[7], 29);
    s[7]  = s[7] + s[8];

    s[12] = s[12] + rotl(s[1], 31);
    s[1]  = s[1] + rotl(s[6], 1);
    s[6]  = s[6] + rotl(s[11], 2);
    s[11] = s[11] + s[12];
    return s;
  endfunction

endpackage

>>> design/arx_cfg.sv
module arx_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  output arx_pkg::block_t                load_image
);
  import arx_pkg::*;

  logic [63:0] key01;
  logic [63:0] key23;
  logic [63:0] key45;
  logic [63:0] key67;
  logic [63:0] nonce01;
  logic [63:0] nonce23;
  logic [31:0] nonce4;
  logic [31:0] counter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key01   <= '0;
      key23   <= '0;
      key45   <= '0;
      key67   <= '0;
      nonce01 <= '0;
      nonce23 <= '0;
      nonce4  <= '0;
      counter <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY01:   key01   <= cfg_data;
        REG_KEY23:   key23   <= cfg_data;
        REG_KEY45:   key45   <= cfg_data;
        REG_KEY67:   key67   <= cfg_data;
        REG_NONCE01: nonce01 <= cfg_data;
        REG_NONCE23: nonce23 <= cfg_data;
        REG_NONCE4:  nonce4  <= cfg_data[31:0];
        REG_COUNTER: counter <= cfg_data[31:0];
        default:     key01   <= key01;
      endcase
    end
  end

  assign load_image = build_image(key01, key23, key45, key67, nonce01, nonce23, nonce4, counter);

endmodule

>>> design/arx_front.sv
module arx_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           action,
  input  logic [7:0]     data_byte,
  input  logic           ends_call,
  output logic           head_valid,
  output arx_pkg::item_t head,
  input  logic           pop
);
  import arx_pkg::*;

  item_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              do_pop;
  item_t             entry;

  assign in_ready   = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && head_valid;
  assign head       = queue[rd_ptr];

  always_comb begin
    entry.restart = action;
    entry.data    = data_byte;
    entry.ends    = ends_call;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/arx_keygen.sv
module arx_keygen #(
  parameter int ROUND_PAIRS = arx_pkg::ROUND_PAIRS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  arx_pkg::block_t   load_image,
  input  arx_pkg::kg_ctrl_t ctrl,
  output logic              blk_valid,
  output arx_pkg::block_t   blk
);
  import arx_pkg::*;

  localparam int ROUNDS = 2 * ROUND_PAIRS;
  localparam int RND_W  = $clog2(ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  block_t           cs;
  block_t           ws;
  block_t           ws_mixed;
  logic [RND_W-1:0] rnd;
  logic             busy;
  logic             start;
  logic             step;
  logic             finish;

  assign ws_mixed = mix(ws);

  // A new block is started as soon as the round unit is free, so the next
  // block is ready well before the byte engine runs out of the current one.
  assign start  = !busy && !ctrl.restart;
  assign step   = busy && (rnd != RND_LAST) && !ctrl.restart;
  assign finish = busy && (rnd == RND_LAST) && !ctrl.restart && (!blk_valid || ctrl.take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cs        <= build_image('0, '0, '0, '0, '0, '0, '0, '0);
      busy      <= 1'b0;
      rnd       <= '0;
      blk_valid <= 1'b0;
    end else if (ctrl.restart) begin
      cs        <= load_image;
      busy      <= 1'b0;
      blk_valid <= 1'b0;
    end else begin
      if (start) begin
        // The counter moves on for every block drawn from the state.
        cs[14] <= cs[14] + 32'(cs[15] == '0);
        cs[15] <= cs[15] + 32'd1;
        busy   <= 1'b1;
        rnd    <= '0;
      end else if (step) begin
        rnd <= rnd + 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        blk_valid <= 1'b1;
      end else if (ctrl.take) begin
        blk_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ws <= cs;
    end else if (step) begin
      ws <= ws_mixed;
    end
    if (finish) begin
      blk <= ws_mixed;
    end
  end

endmodule

>>> design/arx_back.sv
module arx_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  arx_pkg::item_t     head,
  output logic               pop,
  output arx_pkg::kg_ctrl_t  ctrl,
  input  logic               blk_valid,
  input  arx_pkg::block_t    blk,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte
);
  import arx_pkg::*;

  localparam logic [POS_W-1:0] POS_EMPTY = POS_W'(BLOCK_BYTES);

  block_t           cur;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             out_free;
  logic             exhausted;
  logic             data_go;
  logic [5:0]       idx;
  block_t           src;
  logic [7:0]       ks;

  assign out_free  = !out_valid || out_ready;
  assign exhausted = pos[POS_W-1];

  always_comb begin
    data_go      = head_valid && !head.restart && out_free && (!exhausted || blk_valid);
    ctrl.restart = head_valid && head.restart;
    ctrl.take    = data_go && exhausted;
    pop          = ctrl.restart || data_go;
  end

  // A fresh block is used directly from the generator for its first byte.
  always_comb begin
    src = exhausted ? blk : cur;
    idx = exhausted ? 6'd0 : pos[5:0];
    ks  = src[idx[5:2]][{idx[1:0], 3'b000} +: 8];
  end

  always_comb begin
    pos_next = pos;
    if (ctrl.restart) begin
      pos_next = POS_EMPTY;
    end else if (data_go) begin
      if (head.ends) begin
        pos_next = POS_EMPTY;
      end else begin
        pos_next = POS_W'(idx) + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_EMPTY;
      out_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (out_free) begin
        out_valid <= data_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      cur <= blk;
    end
    if (data_go) begin
      out_byte <= head.data ^ ks;
    end
  end

endmodule

>>> design/arx_stream_cipher_xor_top.sv
// An accepted byte passes the item queue and then the output register, given a keystream
// block. Throughput: one byte per cycle within a call while the output is taken. A block is
// a load step, then one round per cycle (the last held until the prior block is taken), and
// one is prepared ahead; the first byte after a restart waits for a whole block to be built.
// Reset clears the registers, loads the state image of zero registers, empties the item
// queue and marks the block as used up; a first block is generated at once.
module arx_stream_cipher_xor_top #(
  parameter int ROUND_PAIRS = arx_pkg::ROUND_PAIRS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [7:0]                    data_byte,
  input  logic                          ends_call,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [arx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import arx_pkg::*;

  block_t   load_image;
  item_t    head;
  logic     head_valid;
  logic     pop;
  kg_ctrl_t ctrl;
  logic     blk_valid;
  block_t   blk;

  arx_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .load_image (load_image)
  );

  arx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .data_byte  (data_byte),
    .ends_call  (ends_call),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  arx_keygen #(
    .ROUND_PAIRS (ROUND_PAIRS)
  ) u_keygen (
    .clk        (clk),
    .rst        (rst),
    .load_image (load_image),
    .ctrl       (ctrl),
    .blk_valid  (blk_valid),
    .blk        (blk)
  );

  arx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ctrl       (ctrl),
    .blk_valid  (blk_valid),
    .blk        (blk),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte)
  );

endmodule
